// ===== src/kpd_pkg.sv =====
package kpd_pkg;

	localparam int ROWS     = 3;
	localparam int COLS     = 3;
	localparam int MATRIX_W = ROWS * COLS;
	localparam int CODE_W   = 4;
	localparam int COUNT_W  = 8;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 8;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [CODE_W-1:0]  KEY_NONE       = 4'd0;
	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd5;

	// digit code per matrix bit, row 0 first
	localparam logic [CODE_W-1:0] DIGIT_OF [MATRIX_W] = '{
		4'd7, 4'd8, 4'd9,
		4'd4, 4'd5, 4'd6,
		4'd1, 4'd2, 4'd3
	};

	typedef struct packed {
		logic              cmd;
		logic [CODE_W-1:0] code;
	} kpd_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] read_key;
		logic [CODE_W-1:0] stable_key;
	} kpd_result_t;

	// first pressed key in scan order wins
	function automatic logic [CODE_W-1:0] scan_code(input logic [MATRIX_W-1:0] m);
		logic [CODE_W-1:0] c;
		c = KEY_NONE;
		for (int i = MATRIX_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				c = DIGIT_OF[i];
			end
		end
		return c;
	endfunction

endpackage

// ===== src/kpd_in_stage.sv =====
module kpd_in_stage
	import kpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_cmd,
	input  logic [MATRIX_W-1:0] in_matrix,
	input  logic                adv,
	output logic                valid_s1,
	output kpd_item_t           item_s1
);

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// decode the scan on the way in, matrix is ignored for reads
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.cmd  <= in_cmd;
			item_s1.code <= (in_cmd == CMD_TICK) ? scan_code(in_matrix) : KEY_NONE;
		end
	end

endmodule

// ===== src/kpd_track.sv =====
module kpd_track
	import kpd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  kpd_item_t          item,
	input  logic [COUNT_W-1:0] debounce_ticks,
	output kpd_result_t        result
);

	logic [CODE_W-1:0]  key_buffer_q;
	logic [CODE_W-1:0]  validated_q;
	logic [CODE_W-1:0]  previous_q;
	logic [COUNT_W-1:0] repeat_count_q;

	logic [CODE_W-1:0]  key_buffer_d;
	logic [CODE_W-1:0]  validated_d;
	logic [CODE_W-1:0]  previous_d;
	logic [COUNT_W-1:0] repeat_count_d;
	logic [COUNT_W-1:0] count_inc;
	logic [CODE_W-1:0]  read_val;

	assign count_inc = repeat_count_q + 8'd1;

	always_comb begin
		key_buffer_d   = key_buffer_q;
		validated_d    = validated_q;
		previous_d     = previous_q;
		repeat_count_d = repeat_count_q;
		read_val       = KEY_NONE;
		if (item.cmd == CMD_READ) begin
			read_val     = key_buffer_q;
			key_buffer_d = KEY_NONE;
		end else if (item.code == validated_q) begin
			previous_d     = item.code;
			repeat_count_d = '0;
		end else if (item.code == previous_q) begin
			repeat_count_d = count_inc;
			if (count_inc >= debounce_ticks) begin
				key_buffer_d   = item.code;
				validated_d    = item.code;
				repeat_count_d = '0;
			end
		end else begin
			previous_d     = item.code;
			repeat_count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_buffer_q   <= KEY_NONE;
			validated_q    <= KEY_NONE;
			previous_q     <= KEY_NONE;
			repeat_count_q <= '0;
		end else if (step) begin
			key_buffer_q   <= key_buffer_d;
			validated_q    <= validated_d;
			previous_q     <= previous_d;
			repeat_count_q <= repeat_count_d;
		end
	end

	assign result.read_key   = read_val;
	assign result.stable_key = validated_d;

	// a candidate equal to the validated key never carries a count
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		previous_q == validated_q |-> repeat_count_q == '0)
		else $error("repeat count running on the validated key");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.cmd == CMD_READ |=> key_buffer_q == KEY_NONE)
		else $error("key buffer not cleared by read");

	a_no_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(validated_q) && $stable(key_buffer_q))
		else $error("debounce state moved without a beat");

	a_read_keeps_key: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.cmd == CMD_READ |=> $stable(validated_q))
		else $error("read changed the validated key");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		validated_q <= 4'd9 && key_buffer_q <= 4'd9)
		else $error("key code out of range");

endmodule

// ===== src/keypad_scan_debounce_core.sv =====
// 3x3 keypad scanner and debouncer. Each input beat is a scan tick (tuser 0, tdata carries
// the matrix sample) or a read (tuser 1), and each gives exactly one output beat with the
// buffered key (nonzero only on reads) and the validated key. A beat can be accepted in every
// cycle while the output is not stalled: it is decoded into an input register, runs through the
// debounce compare-and-count logic and lands in the output register; the output register
// and the input register together hold two beats while m_tready is low. debounce_ticks is set
// on the cfg channel, which is always ready, and must only change while no beats are in flight.
module keypad_scan_debounce_core
	import kpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [COUNT_W-1:0]     cfg_data,     // debounce_ticks
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,      // key_matrix[8:0], zeros above
	input  logic                   s_tuser,      // cmd
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata       // read_key[3:0], stable_key[7:4]
);

	logic [COUNT_W-1:0] debounce_ticks_q;
	logic               valid_s1;
	kpd_item_t          item_s1;
	logic               adv;
	logic               step;
	kpd_result_t        result;
	logic               valid_s2;
	kpd_result_t        result_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			debounce_ticks_q <= cfg_data;
		end
	end

	assign adv  = !valid_s2 || m_tready;
	assign step = valid_s1 && adv;

	kpd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_matrix (s_tdata[MATRIX_W-1:0]),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	kpd_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.item           (item_s1),
		.debounce_ticks (debounce_ticks_q),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {result_s2.stable_key, result_s2.read_key};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import kpd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PLAN_ROWS   = 25;
	localparam int PHASES      = 7;

	typedef struct packed {
		logic [CODE_W-1:0] read_key;
		logic [CODE_W-1:0] stable_key;
	} key_report_t;

	typedef struct {
		logic                cmd;
		logic [MATRIX_W-1:0] matrix;
		bit                  fixed;
		logic [CODE_W-1:0]   rk;
		logic [CODE_W-1:0]   sk;
	} plan_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [COUNT_W-1:0]     cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata   = '0;     // key_matrix[8:0], zeros above
	logic                   s_tuser   = 1'b0;   // cmd
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;            // read_key[3:0], stable_key[7:4]

	// typed expectation riding along with the current input beat
	bit                beat_fixed = 1'b0;
	logic [CODE_W-1:0] beat_rk    = '0;
	logic [CODE_W-1:0] beat_sk    = '0;

	// tracked keypad state
	logic [COUNT_W-1:0] hold_ticks  = DEBOUNCE_RESET;
	logic [CODE_W-1:0]  latched_key = KEY_NONE;
	logic [CODE_W-1:0]  stable_now  = KEY_NONE;
	logic [CODE_W-1:0]  cand_key    = KEY_NONE;
	logic [COUNT_W-1:0] cand_count  = '0;

	key_report_t pending_keys [$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          burst_left  = 0;

	plan_row_t plan [PLAN_ROWS];
	int        phase_ticks [PHASES];
	int        phase_beats [PHASES] = '{200, 700, 100, 200, 250, 200, 200};

	keypad_scan_debounce_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// row 0 of the pad reads 7 8 9, the bottom row 1 2 3
	function automatic logic [CODE_W-1:0] first_pressed(input logic [MATRIX_W-1:0] m);
		for (int b = 0; b < MATRIX_W; b++) begin
			if (m[b]) begin
				return CODE_W'((ROWS - 1 - b / COLS) * COLS + b % COLS + 1);
			end
		end
		return KEY_NONE;
	endfunction

	task automatic track_keypad(input logic cmd, input logic [MATRIX_W-1:0] matrix,
			output key_report_t r);
		logic [CODE_W-1:0] code;
		r.read_key = KEY_NONE;
		if (cmd == CMD_READ) begin
			r.read_key  = latched_key;
			latched_key = KEY_NONE;
		end else begin
			code = first_pressed(matrix);
			if (code == stable_now) begin
				cand_key   = code;
				cand_count = '0;
			end else if (code == cand_key) begin
				cand_count = cand_count + 1'b1;
				if (cand_count >= hold_ticks) begin
					latched_key = code;
					stable_now  = code;
					cand_count  = '0;
				end
			end else begin
				cand_key   = code;
				cand_count = '0;
			end
		end
		r.stable_key = stable_now;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < 50) begin
			$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want,
				cycle_count);
		end
		error_count++;
	endtask

	always @(posedge clk) begin : monitor
		key_report_t want;
		key_report_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				hold_ticks = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				track_keypad(s_tuser, s_tdata[MATRIX_W-1:0], want);
				if (beat_fixed) begin
					want.read_key   = beat_rk;
					want.stable_key = beat_sk;
				end
				pending_keys.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.read_key   = m_tdata[3:0];
				got.stable_key = m_tdata[7:4];
				if (pending_keys.size() == 0) begin
					report_mismatch("beat with nothing pending", m_tdata, -1);
				end else begin
					want = pending_keys.pop_front();
					if (got.read_key !== want.read_key) begin
						report_mismatch("read_key", got.read_key, want.read_key);
					end
					if (got.stable_key !== want.stable_key) begin
						report_mismatch("stable_key", got.stable_key, want.stable_key);
					end
				end
			end
		end
	end

	// output side: switches between free flow, random, short and long stall patterns
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;
	always @(posedge clk) begin
		rx_tick++;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(32, 256);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			2: begin
				m_tready <= (rx_tick % 7) >= 2;
			end
			default: begin
				m_tready <= (rx_tick % 23) >= 15;
			end
		endcase
	end

	task automatic send_beat(input logic cmd, input logic [MATRIX_W-1:0] matrix,
			input bit fixed, input logic [CODE_W-1:0] rk, input logic [CODE_W-1:0] sk);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 30);
		end
		burst_left--;
		s_tvalid   <= 1'b1;
		s_tuser    <= cmd;
		s_tdata    <= TDATA_IN_W'(matrix);
		beat_fixed <= fixed;
		beat_rk    <= rk;
		beat_sk    <= sk;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_keys.size() != 0) @(posedge clk);
	endtask

	task automatic write_debounce(input int ticks);
		wait_drained();
		cfg_data  <= COUNT_W'(ticks);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// pressed key at pos with random keys further along the scan; pos past the end = release
	function automatic logic [MATRIX_W-1:0] press_at(input int pos);
		logic [MATRIX_W-1:0] m;
		if (pos >= MATRIX_W) begin
			return '0;
		end
		m = MATRIX_W'($urandom) & ({MATRIX_W{1'b1}} << pos);
		m[pos] = 1'b1;
		return m;
	endfunction

	task automatic run_phase(input int ticks, input int beats);
		int  sent;
		int  kind;
		int  pos;
		int  len;
		bit  broken;
		sent = 0;
		while (sent < beats) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				send_beat(CMD_TICK, MATRIX_W'($urandom), 1'b0, KEY_NONE, KEY_NONE);
				sent++;
			end else if (kind == 1) begin
				repeat ($urandom_range(1, 2)) begin
					send_beat(CMD_READ, MATRIX_W'($urandom), 1'b0, KEY_NONE, KEY_NONE);
					sent++;
				end
			end else begin
				// held key: long enough to pass the debounce in about half the runs
				pos    = $urandom_range(0, MATRIX_W);
				len    = $urandom_range(0, 1) ? ticks + 1 + $urandom_range(0, 2)
					: $urandom_range(1, ticks + 1);
				broken = $urandom_range(0, 3) == 0;
				repeat (len) begin
					if ($urandom_range(0, 15) == 0) begin
						send_beat(CMD_READ, MATRIX_W'($urandom), 1'b0, KEY_NONE, KEY_NONE);
					end else if (broken && $urandom_range(0, 7) == 0) begin
						send_beat(CMD_TICK, MATRIX_W'($urandom), 1'b0, KEY_NONE, KEY_NONE);
					end else begin
						send_beat(CMD_TICK, press_at(pos), 1'b0, KEY_NONE, KEY_NONE);
					end
					sent++;
				end
			end
		end
	endtask

	initial begin
		plan = '{
			'{CMD_READ, 9'h1FF, 1'b1, 4'd0, 4'd0},
			'{CMD_TICK, 9'h000, 1'b1, 4'd0, 4'd0},
			'{CMD_TICK, 9'h1FF, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h1FF, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h1FF, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h1FF, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h1FF, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h1FF, 1'b1, 4'd0, 4'd7},
			'{CMD_READ, 9'h1FF, 1'b1, 4'd7, 4'd7},
			'{CMD_READ, 9'h000, 1'b1, 4'd0, 4'd7},
			'{CMD_TICK, 9'h100, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h080, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h040, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h020, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h010, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h008, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h004, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h002, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h001, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h000, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h000, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h000, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h000, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h000, 1'b0, 4'd0, 4'd0},
			'{CMD_TICK, 9'h000, 1'b0, 4'd0, 4'd0}
		};
		// extremes, zero past the low end, then mixed values; state carries across phases
		phase_ticks = '{1, 255, 0, 2, $urandom_range(3, 12), $urandom_range(1, 255), 3};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			send_beat(plan[i].cmd, plan[i].matrix, plan[i].fixed, plan[i].rk, plan[i].sk);
		end
		beat_fixed <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			write_debounce(phase_ticks[ph]);
			run_phase(phase_ticks[ph], phase_beats[ph]);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
